// File: hw/rtl/ads_pkg.sv
package ads_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_ZERO  = '0;

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FRONT_WR,
    S_EMIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic signed [DATA_W-1:0] wdata;
    logic                     re;
    logic [IDX_W-1:0]         raddr;
  } mem_req_t;

endpackage

// File: hw/rtl/ads_in_if.sv
interface ads_in_if;
  import ads_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

// File: hw/rtl/ads_out_if.sv
interface ads_out_if;
  import ads_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic                     element_valid;
  logic signed [DATA_W-1:0] element;
  logic                     last;

  modport source (output valid, output status, output element_valid, output element,
                  output last, input ready);
  modport sink (input valid, input status, input element_valid, input element,
                input last, output ready);
endinterface

// File: hw/rtl/array_deque_shifting.sv
// Channel  Dir  Beat fields                                  Handshake
// in_ch    in   opcode[1:0], value[31:0] signed               valid / ready
// out_ch   out  status[1:0], element_valid, element[31:0], last  valid / ready
//
// One operation at a time: in_ch.ready is high only while idle.
// An operation returns one result beat per entry left in the queue, or a single
// beat when it is left empty; a front push at slot zero over held entries first
// shifts each up one slot, one read or one write per cycle on the slot memory.
// Reset (rst_n low, synchronous) empties the queue; slot contents are not cleared.
// A stalled result beat holds until taken.
module array_deque_shifting (
  input  logic      clk,
  input  logic      rst_n,
  ads_in_if.sink    in_ch,
  ads_out_if.source out_ch
);
  import ads_pkg::*;

  mem_req_t                 mem_req;
  logic signed [DATA_W-1:0] mem_rdata;

  ads_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .req    (mem_req),
    .rdata  (mem_rdata)
  );

  ads_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_ch.valid && in_ch.ready))
    else $error("result beat offered while accepting a new operation");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("ready stayed high after an accepted operation");

  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.element_valid) |-> (out_ch.last && out_ch.element == '0))
    else $error("empty-queue beat not marked last with zero element");
`endif

endmodule

// File: hw/rtl/ads_mem.sv
module ads_mem (
  input  logic                              clk,
  input  ads_pkg::mem_req_t                 req,
  output logic signed [ads_pkg::DATA_W-1:0] rdata
);
  import ads_pkg::*;

  logic signed [DATA_W-1:0] slot_r [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      slot_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= slot_r[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/ads_ctrl.sv
module ads_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  ads_in_if.sink                            in_ch,
  ads_out_if.source                         out_ch,
  output ads_pkg::mem_req_t                 req,
  input  logic signed [ads_pkg::DATA_W-1:0] rdata
);
  import ads_pkg::*;

  state_t                   state_r, state_nxt;
  logic                     empty_r, empty_nxt;
  logic [IDX_W-1:0]         front_r, front_nxt;
  logic [IDX_W-1:0]         rear_r, rear_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  status_t                  status_r, status_nxt;

  op_t  op;
  logic full;
  logic out_last;

  assign op       = op_t'(in_ch.opcode);
  assign full     = !empty_r && (rear_r == LAST_SLOT);
  assign out_last = empty_r || (idx_r == rear_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      empty_r <= 1'b1;
      front_r <= '0;
      rear_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      empty_r <= empty_nxt;
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    status_r <= status_nxt;
  end

  // next state and index updates
  always_comb begin
    state_nxt  = state_r;
    empty_nxt  = empty_r;
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    idx_nxt    = idx_r;
    value_nxt  = value_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          value_nxt  = in_ch.value;
          status_nxt = ST_OK;
          state_nxt  = S_EMIT;
          unique case (op)
            OP_PUSH_REAR: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else if (empty_r) begin
                empty_nxt = 1'b0;
                front_nxt = IDX_ZERO;
                rear_nxt  = IDX_ZERO;
              end else begin
                rear_nxt = rear_r + IDX_ONE;
              end
            end
            OP_PUSH_FRONT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else if (empty_r) begin
                empty_nxt = 1'b0;
                front_nxt = IDX_ZERO;
                rear_nxt  = IDX_ZERO;
              end else if (front_r != IDX_ZERO) begin
                front_nxt = front_r - IDX_ONE;
              end else begin
                idx_nxt   = rear_r;
                state_nxt = S_SHIFT_RD;
              end
            end
            OP_POP_FRONT: begin
              if (empty_r) begin
                status_nxt = ST_EMPTY;
              end else if (front_r == rear_r) begin
                empty_nxt = 1'b1;
              end else begin
                front_nxt = front_r + IDX_ONE;
              end
            end
            OP_POP_REAR: begin
              if (empty_r) begin
                status_nxt = ST_EMPTY;
              end else if (front_r == rear_r) begin
                empty_nxt = 1'b1;
              end else begin
                rear_nxt = rear_r - IDX_ONE;
              end
            end
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_SHIFT_RD: begin
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        if (idx_r == IDX_ZERO) begin
          state_nxt = S_FRONT_WR;
        end else begin
          idx_nxt   = idx_r - IDX_ONE;
          state_nxt = S_SHIFT_RD;
        end
      end
      S_FRONT_WR: begin
        rear_nxt  = rear_r + IDX_ONE;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        idx_nxt   = front_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          if (out_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_ONE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshakes, memory port, result beat
  always_comb begin
    in_ch.ready          = 1'b0;
    out_ch.valid         = 1'b0;
    out_ch.status        = status_r;
    out_ch.element_valid = !empty_r;
    out_ch.element       = empty_r ? '0 : rdata;
    out_ch.last          = out_last;
    req                  = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        req.wdata   = in_ch.value;
        if (in_ch.valid && !full) begin
          if (op == OP_PUSH_REAR) begin
            req.we    = 1'b1;
            req.waddr = empty_r ? IDX_ZERO : rear_r + IDX_ONE;
          end else if (op == OP_PUSH_FRONT && (empty_r || front_r != IDX_ZERO)) begin
            req.we    = 1'b1;
            req.waddr = empty_r ? IDX_ZERO : front_r - IDX_ONE;
          end
        end
      end
      S_SHIFT_RD: begin
        req.re    = 1'b1;
        req.raddr = idx_r;
      end
      S_SHIFT_WR: begin
        req.we    = 1'b1;
        req.waddr = idx_r + IDX_ONE;
        req.wdata = rdata;
      end
      S_FRONT_WR: begin
        req.we    = 1'b1;
        req.waddr = IDX_ZERO;
        req.wdata = value_r;
      end
      S_EMIT: begin
        req.re    = !empty_r;
        req.raddr = front_r;
      end
      S_OUT: begin
        out_ch.valid = 1'b1;
        req.re       = out_ch.ready && !out_last;
        req.raddr    = idx_r + IDX_ONE;
      end
      default: req = '0;
    endcase
  end

endmodule
